[sv/csvt_pkg.sv]
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants of the CSV field tokenizer: record layout,
// record kinds, error codes, configuration indexes and reset values.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int COLUMN_BITS_DEF = 16;

  localparam int OUT_OFF_W = 32;
  localparam int OUT_COL_W = 16;
  localparam int OUT_ROW_W = 32;
  localparam int MAX_FIELD_W = 32;
  localparam int TDATA_W = 120;

  localparam int MAX_RES = 4;
  localparam int CNT_W = $clog2(MAX_RES + 1);
  localparam int SEL_W = $clog2(MAX_RES);
  localparam int QDEPTH = 2;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  localparam logic [7:0] DELIM_RST = 8'd44;
  localparam logic [7:0] QUOTE_RST = 8'd34;

  localparam logic [1:0] EMODE_REPORT = 2'd0;
  localparam logic [1:0] EMODE_SILENT = 2'd1;
  localparam logic [1:0] EMODE_FAIL = 2'd2;

  typedef enum logic [1:0] {
    KIND_FIELD = 2'd0,
    KIND_ROW   = 2'd1,
    KIND_ERR   = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_SIZE        = 3'd1,
    ERR_QUOTE       = 3'd2,
    ERR_AFTER_QUOTE = 3'd3,
    ERR_UNCLOSED    = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    CFG_DELIM = 3'd0,
    CFG_QUOTE = 3'd1,
    CFG_MAXF  = 3'd2,
    CFG_SKIP  = 3'd3,
    CFG_HDR   = 3'd4,
    CFG_EMODE = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]             delim;
    logic [7:0]             quote;
    logic [MAX_FIELD_W-1:0] max_field;
    logic                   skip_empty;
    logic                   first_hdr;
    logic [1:0]             emode;
  } cfg_t;

  typedef struct packed {
    kind_e                kind;
    logic [OUT_OFF_W-1:0] start_off;
    logic [OUT_OFF_W-1:0] end_off;
    logic                 quoted;
    logic [OUT_COL_W-1:0] column;
    logic [OUT_ROW_W-1:0] row_num;
    logic                 in_hdr;
    err_e                 code;
    logic                 status;
  } rec_t;

  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    rec_t [MAX_RES-1:0]     rec;
  } bundle_t;

endpackage

[sv/csvt_front.sv]
// ----------------------------------------------------------------------------
// csvt_front
// Parser front end: takes one byte or end-of-input beat per clock while the
// bundle queue has room, runs the quote-aware row/field state machine and
// builds the bundle of records that the beat causes.
// ----------------------------------------------------------------------------
module csvt_front #(
  parameter int OFFSET_BITS = csvt_pkg::OFFSET_BITS_DEF,
  parameter int COLUMN_BITS = csvt_pkg::COLUMN_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csvt_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_eoi_i,
  input  logic [7:0]        in_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output csvt_pkg::bundle_t bundle_o
);

  localparam int OW = csvt_pkg::OUT_OFF_W;
  localparam int CW = csvt_pkg::OUT_COL_W;
  localparam int RW = csvt_pkg::OUT_ROW_W;
  localparam int NW = csvt_pkg::CNT_W;
  localparam int SW = (OFFSET_BITS > csvt_pkg::MAX_FIELD_W) ? OFFSET_BITS
                                                              : csvt_pkg::MAX_FIELD_W;

  typedef enum logic [5:0] {
    ST_REC  = 6'b000001,
    ST_FLD  = 6'b000010,
    ST_UNQ  = 6'b000100,
    ST_QUO  = 6'b001000,
    ST_QEND = 6'b010000,
    ST_CR   = 6'b100000
  } pst_e;

  pst_e                   pst_q, pst_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, fbeg_q, fbeg_d, rbeg_q, rbeg_d;
  logic                   fq_q, fq_d;
  logic [COLUMN_BITS-1:0] nfld_q, nfld_d, nfld_mid;
  logic [RW-1:0]          rows_q, rows_d, row_no;
  logic                   hdr_done_q, hdr_done_d;
  logic                   halted_q, halted_d;
  logic                   fatal_q, fatal_d;

  logic                   take, active;
  logic                   is_qt, is_dl, is_lf, is_nl;
  logic [OFFSET_BITS-1:0] nxt, pm1, fs, fe, fsize;
  logic                   pre_err, fld, fqv, row_req, endrow, eoi_quo, stop;
  logic                   too_big, in_hdr, silent, fail;
  csvt_pkg::err_e         pre_code;
  logic [NW-1:0]          n;

  function automatic csvt_pkg::rec_t mk_rec(
    input csvt_pkg::kind_e        k,
    input logic [OFFSET_BITS-1:0] s,
    input logic [OFFSET_BITS-1:0] e,
    input logic                   q,
    input logic [COLUMN_BITS-1:0] col,
    input logic [RW-1:0]          rn,
    input logic                   h,
    input csvt_pkg::err_e         code,
    input logic                   st
  );
    csvt_pkg::rec_t r;
    r.kind      = k;
    r.start_off = OW'(s);
    r.end_off   = OW'(e);
    r.quoted    = q;
    r.column    = CW'(col);
    r.row_num   = rn;
    r.in_hdr    = h;
    r.code      = code;
    r.status    = st;
    return r;
  endfunction

  assign in_ready_o = ~q_full_i;
  assign take       = in_valid_i & ~q_full_i;
  assign active     = take & ~halted_q;

  assign is_qt = (in_byte_i == cfg_i.quote);
  assign is_dl = (in_byte_i == cfg_i.delim);
  assign is_lf = (in_byte_i == csvt_pkg::BYTE_LF);
  assign is_nl = is_lf | (in_byte_i == csvt_pkg::BYTE_CR);

  assign nxt = pos_q + OFFSET_BITS'(1);
  assign pm1 = pos_q - OFFSET_BITS'(1);

  assign silent = (cfg_i.emode == csvt_pkg::EMODE_SILENT);
  assign fail   = (cfg_i.emode >= csvt_pkg::EMODE_FAIL);
  assign in_hdr = cfg_i.first_hdr & ~hdr_done_q;
  assign row_no = in_hdr ? '0 : ((rows_q == '1) ? rows_q : rows_q + RW'(1));

  assign fsize   = fe - fs;
  assign too_big = (cfg_i.max_field != '0) && (SW'(fsize) > SW'(cfg_i.max_field));

  always_comb begin
    pst_d      = pst_q;
    pos_d      = pos_q;
    fbeg_d     = fbeg_q;
    rbeg_d     = rbeg_q;
    fq_d       = fq_q;
    pre_err    = 1'b0;
    pre_code   = csvt_pkg::ERR_NONE;
    fld        = 1'b0;
    fs         = pos_q;
    fe         = pos_q;
    fqv        = fq_q;
    row_req    = 1'b0;
    endrow     = 1'b0;
    eoi_quo    = 1'b0;
    if (active) begin
      if (!in_eoi_i) begin
        pos_d = nxt;
        if (pst_q == ST_CR && is_lf) begin
          pst_d  = ST_REC;
          fbeg_d = nxt;
          rbeg_d = nxt;
        end else begin
          case (pst_q)
            ST_UNQ: begin
              if (is_dl) begin
                fld    = 1'b1;
                fs     = fbeg_q;
                pst_d  = ST_FLD;
                fq_d   = 1'b0;
                fbeg_d = nxt;
              end else if (is_nl) begin
                fld    = 1'b1;
                fs     = fbeg_q;
                endrow = 1'b1;
              end else if (is_qt) begin
                pre_err  = 1'b1;
                pre_code = csvt_pkg::ERR_QUOTE;
              end
            end
            ST_QUO: begin
              if (is_qt) pst_d = ST_QEND;
            end
            ST_QEND: begin
              if (is_qt) begin
                pst_d = ST_QUO;
              end else if (is_dl) begin
                fld    = 1'b1;
                fs     = fbeg_q;
                fe     = pm1;
                pst_d  = ST_FLD;
                fq_d   = 1'b0;
                fbeg_d = nxt;
              end else if (is_nl) begin
                fld    = 1'b1;
                fs     = fbeg_q;
                fe     = pm1;
                endrow = 1'b1;
              end else begin
                pre_err  = 1'b1;
                pre_code = csvt_pkg::ERR_AFTER_QUOTE;
                pst_d    = ST_UNQ;
              end
            end
            default: begin
              if (is_qt) begin
                pst_d  = ST_QUO;
                fq_d   = 1'b1;
                fbeg_d = nxt;
              end else if (is_dl) begin
                fld    = 1'b1;
                fqv    = 1'b0;
                pst_d  = ST_FLD;
                fq_d   = 1'b0;
                fbeg_d = nxt;
              end else if (is_nl) begin
                fld    = (pst_q == ST_FLD) || (nfld_q != '0);
                fqv    = 1'b0;
                endrow = 1'b1;
              end else begin
                pst_d  = ST_UNQ;
                fq_d   = 1'b0;
                fbeg_d = pos_q;
              end
            end
          endcase
          if (endrow) begin
            row_req = 1'b1;
            pst_d   = is_lf ? ST_REC : ST_CR;
            fq_d    = 1'b0;
            rbeg_d  = nxt;
            fbeg_d  = nxt;
          end
        end
      end else begin
        case (pst_q)
          ST_UNQ: begin
            fld     = 1'b1;
            fs      = fbeg_q;
            row_req = 1'b1;
          end
          ST_QUO: begin
            eoi_quo  = 1'b1;
            pre_err  = 1'b1;
            pre_code = csvt_pkg::ERR_UNCLOSED;
            fld      = ~fail;
            fs       = fbeg_q;
            row_req  = ~fail;
          end
          ST_QEND: begin
            fld     = 1'b1;
            fs      = fbeg_q;
            fe      = pm1;
            row_req = 1'b1;
          end
          ST_FLD: begin
            fld     = 1'b1;
            row_req = 1'b1;
          end
          default: begin
            row_req = (nfld_q != '0);
          end
        endcase
      end
    end
  end

  always_comb begin
    n          = '0;
    bundle_o   = '0;
    stop       = 1'b0;
    nfld_mid   = nfld_q;
    hdr_done_d = hdr_done_q;
    rows_d     = rows_q;
    halted_d   = halted_q;
    if (pre_err && !silent) begin
      bundle_o.rec[n[csvt_pkg::SEL_W-1:0]] = mk_rec(csvt_pkg::KIND_ERR, fbeg_q, pos_q, 1'b0,
          nfld_q, row_no, in_hdr, pre_code, 1'b0);
      n    = n + NW'(1);
      stop = fail;
    end
    if (fld) begin
      if (too_big) begin
        if (!silent) begin
          bundle_o.rec[n[csvt_pkg::SEL_W-1:0]] = mk_rec(csvt_pkg::KIND_ERR, fbeg_q, pos_q,
              1'b0, nfld_q, row_no, in_hdr, csvt_pkg::ERR_SIZE, 1'b0);
          n    = n + NW'(1);
          stop = stop | fail;
        end
      end else begin
        bundle_o.rec[n[csvt_pkg::SEL_W-1:0]] = mk_rec(csvt_pkg::KIND_FIELD, fs, fe, fqv,
            nfld_q, row_no, in_hdr, csvt_pkg::ERR_NONE, 1'b0);
        n        = n + NW'(1);
        nfld_mid = (nfld_q == '1) ? nfld_q : nfld_q + COLUMN_BITS'(1);
      end
    end
    nfld_d = nfld_mid;
    if (row_req && !(cfg_i.skip_empty && nfld_mid == '0)) begin
      bundle_o.rec[n[csvt_pkg::SEL_W-1:0]] = mk_rec(csvt_pkg::KIND_ROW, rbeg_q, pos_q, 1'b0,
          nfld_mid, row_no, in_hdr, csvt_pkg::ERR_NONE, 1'b0);
      n = n + NW'(1);
      if (in_hdr) begin
        hdr_done_d = 1'b1;
      end else if (rows_q != '1) begin
        rows_d = rows_q + RW'(1);
      end
      nfld_d = '0;
    end
    fatal_d = fatal_q | stop | eoi_quo;
    if ((active && in_eoi_i) || stop) begin
      bundle_o.rec[n[csvt_pkg::SEL_W-1:0]] = mk_rec(csvt_pkg::KIND_DONE, '0, pos_d, 1'b0,
          '0, rows_d, 1'b0, csvt_pkg::ERR_NONE, fatal_d);
      n        = n + NW'(1);
      halted_d = 1'b1;
    end
    bundle_o.cnt = n;
  end

  assign push_o = (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q      <= ST_REC;
      pos_q      <= '0;
      fbeg_q     <= '0;
      rbeg_q     <= '0;
      fq_q       <= 1'b0;
      nfld_q     <= '0;
      rows_q     <= '0;
      hdr_done_q <= 1'b0;
      halted_q   <= 1'b0;
      fatal_q    <= 1'b0;
    end else if (active) begin
      pst_q      <= pst_d;
      pos_q      <= pos_d;
      fbeg_q     <= fbeg_d;
      rbeg_q     <= rbeg_d;
      fq_q       <= fq_d;
      nfld_q     <= nfld_d;
      rows_q     <= rows_d;
      hdr_done_q <= hdr_done_d;
      halted_q   <= halted_d;
      fatal_q    <= fatal_d;
    end
  end

endmodule

[sv/csvt_fifo.sv]
// ----------------------------------------------------------------------------
// csvt_fifo
// Short queue of record bundles between the parser and the output stage.
// ----------------------------------------------------------------------------
module csvt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csvt_pkg::bundle_t data_i,
  input  logic              pop_i,
  output csvt_pkg::bundle_t data_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int DEPTH = csvt_pkg::QDEPTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csvt_pkg::bundle_t mem_q [DEPTH];
  logic [AW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    if (do_pop) rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[sv/csvt_back.sv]
// ----------------------------------------------------------------------------
// csvt_back
// Output stage: holds one bundle and hands its records out one beat at a
// time, marking the final record of the bundle.
// ----------------------------------------------------------------------------
module csvt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csvt_pkg::bundle_t q_data_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output csvt_pkg::rec_t    out_rec_o,
  output logic              out_last_o
);

  localparam int SW = csvt_pkg::SEL_W;
  localparam int NW = csvt_pkg::CNT_W;

  csvt_pkg::bundle_t cur_q;
  logic              have_q;
  logic [SW-1:0]     sel_q;
  logic              advance;

  assign out_valid_o = have_q;
  assign out_rec_o   = cur_q.rec[sel_q];
  assign out_last_o  = (NW'(sel_q) == cur_q.cnt - NW'(1));
  assign advance     = ~have_q | (out_ready_i & out_last_o);
  assign q_pop_o     = advance & ~q_empty_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      sel_q  <= '0;
    end else if (advance) begin
      have_q <= ~q_empty_i;
      sel_q  <= '0;
    end else if (out_ready_i) begin
      sel_q <= sel_q + SW'(1);
    end
  end

endmodule

[sv/csv_field_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top
// Quote-aware CSV tokenizer producing field, row-end, error and done records.
// ----------------------------------------------------------------------------
// The parser takes one input beat (a data byte or the end-of-input marker) per
// clock whenever its two-entry bundle queue has room, and turns it into up to
// four records in the same cycle. The output stage sends one record per clock
// while the downstream is ready; a stream in which each byte causes at most one
// record runs at one byte per clock, and the queue absorbs short bursts of
// multi-record beats. Records pass from the bundle queue through the output
// stage's bundle register. There is no clearing pass after reset. Configuration
// must be written through the plain write port while the block is idle; the
// block itself does not enforce this. After the stream-done record the block
// takes beats but gives no more records until reset.
module csv_field_tokenizer_top #(
  parameter int OFFSET_BITS = csvt_pkg::OFFSET_BITS_DEF,
  parameter int COLUMN_BITS = csvt_pkg::COLUMN_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [csvt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csvt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // byte_value
  input  logic [7:0]                      s_axis_tdata,
  // mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // start_offset, end_offset, quoted, column, row_number, in_header,
  // error_code, end_status, zero pad
  output logic [csvt_pkg::TDATA_W-1:0]    m_axis_tdata,
  // kind
  output logic [1:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);

  csvt_pkg::cfg_t    cfg_q;
  csvt_pkg::bundle_t push_bundle, pop_bundle;
  csvt_pkg::rec_t    out_rec;
  logic              push, pop, q_empty, q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim      <= csvt_pkg::DELIM_RST;
      cfg_q.quote      <= csvt_pkg::QUOTE_RST;
      cfg_q.max_field  <= '0;
      cfg_q.skip_empty <= 1'b1;
      cfg_q.first_hdr  <= 1'b1;
      cfg_q.emode      <= csvt_pkg::EMODE_REPORT;
    end else if (cfg_we_i) begin
      case (csvt_pkg::cfg_idx_e'(cfg_idx_i))
        csvt_pkg::CFG_DELIM: cfg_q.delim      <= cfg_wdata_i[7:0];
        csvt_pkg::CFG_QUOTE: cfg_q.quote      <= cfg_wdata_i[7:0];
        csvt_pkg::CFG_MAXF:  cfg_q.max_field  <= cfg_wdata_i[csvt_pkg::MAX_FIELD_W-1:0];
        csvt_pkg::CFG_SKIP:  cfg_q.skip_empty <= cfg_wdata_i[0];
        csvt_pkg::CFG_HDR:   cfg_q.first_hdr  <= cfg_wdata_i[0];
        csvt_pkg::CFG_EMODE: cfg_q.emode      <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  csvt_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_eoi_i   (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .push_o     (push),
    .bundle_o   (push_bundle)
  );

  csvt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_bundle),
    .pop_i   (pop),
    .data_o  (pop_bundle),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  csvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (pop_bundle),
    .q_empty_i   (q_empty),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rec_o   (out_rec),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_rec.kind;
  assign m_axis_tdata = {2'b00, out_rec.status, out_rec.code, out_rec.in_hdr,
                         out_rec.row_num, out_rec.column, out_rec.quoted,
                         out_rec.end_off, out_rec.start_off};

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("bundle pushed into a full queue");

  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == csvt_pkg::KIND_DONE) |-> m_axis_tlast)
    else $error("stream-done record not marked last");

  a_nothing_after_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser == csvt_pkg::KIND_DONE)
      |=> !m_axis_tvalid)
    else $error("record sent after stream-done");

  a_error_has_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == csvt_pkg::KIND_ERR)
      |-> (out_rec.code != csvt_pkg::ERR_NONE))
    else $error("error record without an error code");

endmodule
